### rtl/core/ftfsk_pkg.sv
// shared types, constants and sine table builder for the four-tone fsk generator
`default_nettype none

package ftfsk_pkg;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_BASE_STEP          = 3'd0,
        CFG_TONE_STEP          = 3'd1,
        CFG_SAMPLES_PER_SYMBOL = 3'd2,
        CFG_SYMBOL_COUNT       = 3'd3,
        CFG_PERIOD_SAMPLES     = 3'd4
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] RST_BASE_STEP          = 32'd402653184;
    localparam logic [31:0] RST_TONE_STEP          = 32'd393216;
    localparam logic [15:0] RST_SAMPLES_PER_SYMBOL = 16'd10922;
    localparam logic [8:0]  RST_SYMBOL_COUNT       = 9'd162;
    localparam logic [23:0] RST_PERIOD_SAMPLES     = 24'd1920000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] Q60_ONE = 64'h1000000000000000;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  symbol_index;
        logic [1:0]  symbol_value;
    } t_in;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               period_start;
    } t_out;

    typedef struct packed {
        logic        tick;
        logic [7:0]  symbol_index;
        logic [1:0]  symbol_value;
    } t_req;

    typedef struct packed {
        logic [31:0] base_step;
        logic [31:0] tone_step;
        logic [15:0] samples_per_symbol;
        logic [8:0]  symbol_count;
        logic [23:0] period_samples;
    } t_cfg;

    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int unsigned sh);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return 64'(p >> sh);
    endfunction

    // quarter-wave magnitude in q15, odd taylor series through x^17 in q60
    function automatic logic [15:0] sine_quarter(input int unsigned q, input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] m;
        int unsigned ql;
        ql = 32'd1 << (bits - 2);
        if (q == 0) begin
            return 16'd0;
        end
        if (q >= ql) begin
            return 16'h8000;
        end
        x  = mul_shift(PI_Q60, 64'(q), bits - 1);
        x2 = mul_shift(x, x, 60);
        t  = Q60_ONE;
        t  = Q60_ONE - mul_shift(x2, t, 60) / 64'd272;
        t  = Q60_ONE - mul_shift(x2, t, 60) / 64'd210;
        t  = Q60_ONE - mul_shift(x2, t, 60) / 64'd156;
        t  = Q60_ONE - mul_shift(x2, t, 60) / 64'd110;
        t  = Q60_ONE - mul_shift(x2, t, 60) / 64'd72;
        t  = Q60_ONE - mul_shift(x2, t, 60) / 64'd42;
        t  = Q60_ONE - mul_shift(x2, t, 60) / 64'd20;
        t  = Q60_ONE - mul_shift(x2, t, 60) / 64'd6;
        s  = mul_shift(x, t, 60);
        m  = s >> 45;
        if (m > 64'd32767) begin
            m = 64'd32767;
        end
        return 16'(m);
    endfunction

endpackage

`default_nettype wire

### rtl/core/ftfsk_front.sv
// front end: configuration registers and request intake and classification
`default_nettype none

module ftfsk_front import ftfsk_pkg::*; #(
    parameter int SYMBOL_DEPTH = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_in                   i_in,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_full,
    output logic                       o_push,
    output t_req                       o_req,
    output t_cfg                       o_cfg
);

    logic [31:0] r_base_step;
    logic [31:0] r_tone_step;
    logic [15:0] r_spp;
    logic [8:0]  r_symbol_count;
    logic [23:0] r_period;
    logic        idx_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_step    <= RST_BASE_STEP;
            r_tone_step    <= RST_TONE_STEP;
            r_spp          <= RST_SAMPLES_PER_SYMBOL;
            r_symbol_count <= RST_SYMBOL_COUNT;
            r_period       <= RST_PERIOD_SAMPLES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_STEP:          r_base_step    <= i_cfg_data;
                CFG_TONE_STEP:          r_tone_step    <= i_cfg_data;
                CFG_SAMPLES_PER_SYMBOL: r_spp          <= i_cfg_data[15:0];
                CFG_SYMBOL_COUNT:       r_symbol_count <= i_cfg_data[8:0];
                CFG_PERIOD_SAMPLES:     r_period       <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    // zero lengths behave as one
    always_comb begin
        o_cfg.base_step          = r_base_step;
        o_cfg.tone_step          = r_tone_step;
        o_cfg.samples_per_symbol = (r_spp == '0) ? 16'd1 : r_spp;
        o_cfg.symbol_count       = r_symbol_count;
        o_cfg.period_samples     = (r_period == '0) ? 24'd1 : r_period;
    end

    // loads beyond the store are taken and dropped
    assign idx_ok     = (32'(i_in.symbol_index) < SYMBOL_DEPTH);
    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && o_in_ready && ((i_in.cmd == CMD_TICK) || idx_ok);

    always_comb begin
        o_req.tick         = (i_in.cmd == CMD_TICK);
        o_req.symbol_index = i_in.symbol_index;
        o_req.symbol_value = i_in.symbol_value;
    end

endmodule

`default_nettype wire

### rtl/core/ftfsk_queue.sv
// small request queue between front end and back end
`default_nettype none

module ftfsk_queue import ftfsk_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_req i_req,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_req      o_req
);

    t_req                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + QUEUE_CW'(1);
                2'b01:   r_count <= r_count - QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/ftfsk_back.sv
// back end: symbol store, position counters, phase accumulator and sine table
`default_nettype none

module ftfsk_back import ftfsk_pkg::*; #(
    parameter int SYMBOL_DEPTH    = 256,
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_req_valid,
    input  wire t_req i_req,
    output logic      o_req_pop,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out
);

    localparam int AW = (SYMBOL_DEPTH > 1) ? $clog2(SYMBOL_DEPTH) : 1;
    localparam int CW = (AW > 9) ? AW : 9;
    localparam int SW = (PHASE_BITS > 34) ? PHASE_BITS : 34;
    localparam int TW = SINE_TABLE_BITS;
    localparam int QL = 2 ** (TW - 2);
    localparam int RW = TW - 1;

    logic [15:0]         w_rom [QL+1];
    logic [1:0]          r_store [SYMBOL_DEPTH];
    logic [PHASE_BITS-1:0] r_step [4];

    logic                en;
    logic                pop_tick;
    logic [23:0]         r_pp;
    logic [15:0]         r_sis;
    logic [AW-1:0]       r_pos;
    logic                r_past;
    logic [23:0]         n_pp;
    logic [15:0]         n_sis;
    logic                wrap;
    logic                sym_done;
    logic [AW-1:0]       rd_addr;

    logic                r_s1_valid;
    logic                r_s1_wrap;
    logic                r_s1_pstart;
    logic [1:0]          r_tone;

    logic [PHASE_BITS-1:0] r_phase;
    logic                r_s2_valid;
    logic [TW-1:0]       r_s2_idx;
    logic                r_s2_pstart;

    logic                r_s3_valid;
    logic [15:0]         r_s3_sample;
    logic                r_s3_pstart;

    logic [1:0]          quad;
    logic [RW-1:0]       rom_addr;
    logic [15:0]         mag;
    logic [15:0]         sample_c;

    for (genvar g = 0; g <= QL; g++) begin : g_rom
        assign w_rom[g] = sine_quarter(g, SINE_TABLE_BITS);
    end

    // whole pipeline moves when the output register can take a new sample
    assign en        = !r_s3_valid || i_out_ready;
    assign o_req_pop = en && i_req_valid;
    assign pop_tick  = o_req_pop && i_req.tick;

    assign n_pp     = r_pp + 24'd1;
    assign wrap     = (n_pp >= i_cfg.period_samples) || (n_pp == '0);
    assign n_sis    = r_sis + 16'd1;
    assign sym_done = (n_sis >= i_cfg.samples_per_symbol);
    assign rd_addr  = (!r_past && (CW'(r_pos) < CW'(i_cfg.symbol_count))) ? r_pos : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp   <= '0;
            r_sis  <= '0;
            r_pos  <= '0;
            r_past <= 1'b0;
        end else if (pop_tick) begin
            if (wrap) begin
                r_pp   <= '0;
                r_sis  <= '0;
                r_pos  <= '0;
                r_past <= 1'b0;
            end else begin
                r_pp <= n_pp;
                if (sym_done) begin
                    r_sis <= '0;
                    if (r_pos == AW'(SYMBOL_DEPTH - 1)) begin
                        r_past <= 1'b1;
                    end else begin
                        r_pos <= r_pos + AW'(1);
                    end
                end else begin
                    r_sis <= n_sis;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_pop) begin
            if (i_req.tick) begin
                r_tone <= r_store[rd_addr];
            end else begin
                r_store[AW'(i_req.symbol_index)] <= i_req.symbol_value;
            end
        end
    end

    // per-tone phase increments
    always_ff @(posedge i_clk) begin
        r_step[0] <= PHASE_BITS'(SW'(i_cfg.base_step));
        r_step[1] <= PHASE_BITS'(SW'(i_cfg.base_step) + SW'(i_cfg.tone_step));
        r_step[2] <= PHASE_BITS'(SW'(i_cfg.base_step) + (SW'(i_cfg.tone_step) << 1));
        r_step[3] <= PHASE_BITS'(SW'(i_cfg.base_step) + SW'(i_cfg.tone_step)
                                 + (SW'(i_cfg.tone_step) << 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_phase    <= '0;
        end else if (en) begin
            r_s1_valid <= pop_tick;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            if (r_s1_valid) begin
                r_phase <= r_s1_wrap ? '0 : r_phase + r_step[r_tone];
            end
        end
    end

    assign quad     = r_s2_idx[TW-1 -: 2];
    assign rom_addr = quad[0] ? (RW'(QL) - RW'(r_s2_idx[TW-3:0])) : RW'(r_s2_idx[TW-3:0]);
    assign mag      = w_rom[rom_addr];
    assign sample_c = quad[1] ? 16'(-mag) : (mag[15] ? 16'h7FFF : mag);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_wrap   <= wrap;
            r_s1_pstart <= (r_pp == '0);
            r_s2_idx    <= r_phase[PHASE_BITS-1 -: TW];
            r_s2_pstart <= r_s1_pstart;
            r_s3_sample <= sample_c;
            r_s3_pstart <= r_s2_pstart;
        end
    end

    assign o_out_valid = r_s3_valid;
    always_comb begin
        o_out.sample       = r_s3_sample;
        o_out.period_start = r_s3_pstart;
    end

`ifndef SYNTHESIS
    ap_phase_zero_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_s1_valid && r_s1_pstart) |-> (r_phase == '0))
        else $error("phase not zero at period start");

    ap_past_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_past |-> (r_pos == AW'(SYMBOL_DEPTH - 1)))
        else $error("past end set below last position");

    ap_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s3_valid) |-> $past(r_s2_valid))
        else $error("output valid without a sample in flight");
`endif

endmodule

`default_nettype wire

### rtl/core/four_tone_fsk_tone_generator.sv
// top level of the continuous-phase four-tone fsk tone generator
// latency: an accepted sample request passes through stages s1 and s2 to the s3 output register
// throughput: one request per cycle while the output is not stalled, loads and sample ticks alike; loads give no output
// rate set by the phase update fed by the registered symbol store read
// output stalls back up through a 4-entry request queue
// sync active-low reset restores config, clears counters, phase and pipeline, not the store
`default_nettype none

module four_tone_fsk_tone_generator import ftfsk_pkg::*; #(
    parameter int SYMBOL_DEPTH    = 256,
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_in                   i_in,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    output t_out                       o_out,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_req push_req;
    t_req pop_req;
    t_cfg cfg;
    logic push;
    logic full;
    logic pop;
    logic req_valid;

    ftfsk_front #(
        .SYMBOL_DEPTH (SYMBOL_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (full),
        .o_push     (push),
        .o_req      (push_req),
        .o_cfg      (cfg)
    );

    ftfsk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (req_valid),
        .o_req   (pop_req)
    );

    ftfsk_back #(
        .SYMBOL_DEPTH    (SYMBOL_DEPTH),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req_valid (req_valid),
        .i_req       (pop_req),
        .o_req_pop   (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
